>>> rtl/tgapsd_pkg.sv
// ----------------------------------------------------------------------------
// TGA pixel stream decoder package
// Shared payload types, phase encoding and register and field codes.
// ----------------------------------------------------------------------------
package tgapsd_pkg;

    // One input byte of the file body.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_image;
    } tgapsd_in_t;

    // One decoded pixel or run.
    typedef struct packed {
        logic [31:0] pixel_bgra;
        logic [7:0]  repeat_count;
        logic        last_of_image;
        logic        index_error;
    } tgapsd_out_t;

    // Decoder phase, one-hot.
    typedef enum logic [3:0] {
        PH_SKIP = 4'b0001,
        PH_MAP  = 4'b0010,
        PH_PIX  = 4'b0100,
        PH_DONE = 4'b1000
    } tgapsd_phase_t;

    // Result waiting for the color table read to complete.
    typedef struct packed {
        logic        lookup;
        logic        short_entry;
        logic [31:0] value;
        logic [7:0]  rep;
        logic        last;
        logic        err;
    } tgapsd_pend_t;

    // Configuration register indexes.
    localparam logic [2:0] REG_DATA_MODE   = 3'd0;
    localparam logic [2:0] REG_PIXEL_BYTES = 3'd1;
    localparam logic [2:0] REG_MAP_FORMAT  = 3'd2;
    localparam logic [2:0] REG_MAP_LENGTH  = 3'd3;
    localparam logic [2:0] REG_WIDTH       = 3'd4;
    localparam logic [2:0] REG_HEIGHT      = 3'd5;
    localparam logic [2:0] REG_ID_LENGTH   = 3'd6;

    // Data modes.
    localparam logic [1:0] MODE_CMAP = 2'd0;
    localparam logic [1:0] MODE_TRUE = 2'd1;
    localparam logic [1:0] MODE_RLE  = 2'd2;

    // Color map entry formats.
    localparam logic [1:0] FMT_16 = 2'd0;
    localparam logic [1:0] FMT_24 = 2'd1;
    localparam logic [1:0] FMT_32 = 2'd2;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

endpackage

>>> rtl/tgapsd_cmap.sv
// ----------------------------------------------------------------------------
// Color map storage
// Single-port-write, registered-read memory holding the 32-bit BGRA entries.
// ----------------------------------------------------------------------------
module tgapsd_cmap #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [31:0]   wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [31:0]   rd_data
);

    logic [31:0] mem [DEPTH];

    // Entry write during color map load.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered lookup; data holds until the next read.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/tga_pixel_stream_decoder_unit.sv
// ----------------------------------------------------------------------------
// TGA pixel stream decoder
// Skips the image ID, loads the color map and turns body bytes into BGRA pixels.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle on s_ while the output does not stall.
// Results: the byte that completes a result moves it into one pending stage for
//   the color table read, then into the m_ output register when m_ is free.
// Reset: aresetn (synchronous, active low) clears control, phase and counters
//   and restores register defaults; the color table is left as is and is only
//   valid once loaded, so no clearing pass is needed.
module tga_pixel_stream_decoder_unit
    import tgapsd_pkg::*;
#(
    parameter int MAP_DEPTH = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  tgapsd_in_t  s_payload,
    output logic        m_valid,
    input  logic        m_ready,
    output tgapsd_out_t m_payload
);

    localparam int          AW      = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
    localparam logic [32:0] DEPTH_W = 33'(MAP_DEPTH);

    // Configuration registers.
    logic [1:0]  data_mode_reg;
    logic [2:0]  pixel_bytes_reg;
    logic [1:0]  map_fmt_reg;
    logic [8:0]  map_length_reg;
    logic [15:0] width_reg;
    logic [15:0] height_reg;
    logic [7:0]  id_length_reg;
    logic [31:0] area_reg;

    // Decoder state.
    tgapsd_phase_t phase_reg, phase_next;
    logic [1:0]    big_reg, big_next;
    logic [31:0]   aw_reg, aw_next;
    logic [7:0]    skip_reg, skip_next;
    logic [8:0]    ei_reg, ei_next;
    logic [31:0]   pl_reg, pl_next;
    logic [7:0]    pkl_reg, pkl_next;
    logic          raw_reg, raw_next;

    // State as seen by the current byte, after a possible restart.
    tgapsd_phase_t ph_e;
    logic [1:0]    big_e;
    logic [31:0]   aw_e;
    logic [7:0]    skip_e;
    logic [8:0]    ei_e;
    logic [31:0]   pl_e;
    logic [7:0]    pkl_e;
    logic          raw_e;

    // Pipeline stages.
    logic          p_valid_reg;
    tgapsd_pend_t  p_reg;
    tgapsd_pend_t  pend;
    logic          res_valid;
    logic          m_valid_reg;
    tgapsd_out_t   m_payload_reg;
    logic          m_free;
    logic          accept;

    // Group assembly and table access.
    logic [2:0]    pix_grp;
    logic [2:0]    map_grp;
    logic [2:0]    grp;
    logic [31:0]   gath;
    logic          grp_done;
    logic          cmap_entries;
    logic [31:0]   entry;
    logic [8:0]    ei_inc;
    logic [31:0]   pl_after;
    logic          bad_index;
    logic          wr_en;
    logic          rd_en;
    logic [31:0]   rd_data;

    assign m_free  = !m_valid_reg || m_ready;
    assign s_ready = !p_valid_reg || m_free;
    assign accept  = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // Bytes per group for pixels and for map entries, with odd codes folded.
    always_comb begin
        if (data_mode_reg == MODE_CMAP) begin
            pix_grp = (pixel_bytes_reg >= 3'd1 && pixel_bytes_reg <= 3'd4)
                      ? pixel_bytes_reg : 3'd4;
        end else begin
            pix_grp = (pixel_bytes_reg == 3'd4) ? 3'd4 : 3'd3;
        end
        case (map_fmt_reg)
            FMT_16:  map_grp = 3'd2;
            FMT_24:  map_grp = 3'd3;
            default: map_grp = 3'd4;
        endcase
    end

    assign cmap_entries = (data_mode_reg == MODE_CMAP) && (map_length_reg != 9'd0);

    // Restart on start of image, then per-phase byte handling.
    always_comb begin
        ph_e   = phase_reg;
        big_e  = big_reg;
        aw_e   = aw_reg;
        skip_e = skip_reg;
        ei_e   = ei_reg;
        pl_e   = pl_reg;
        pkl_e  = pkl_reg;
        raw_e  = raw_reg;
        if (s_payload.start_of_image) begin
            pl_e   = area_reg;
            skip_e = id_length_reg;
            ei_e   = 9'd0;
            big_e  = 2'd0;
            aw_e   = 32'd0;
            pkl_e  = 8'd0;
            raw_e  = 1'b0;
            if (id_length_reg != 8'd0) begin
                ph_e = PH_SKIP;
            end else if (cmap_entries) begin
                ph_e = PH_MAP;
            end else begin
                ph_e = (area_reg != 32'd0) ? PH_PIX : PH_DONE;
            end
        end

        phase_next = ph_e;
        big_next   = big_e;
        aw_next    = aw_e;
        skip_next  = skip_e;
        ei_next    = ei_e;
        pl_next    = pl_e;
        pkl_next   = pkl_e;
        raw_next   = raw_e;

        grp      = (ph_e == PH_MAP) ? map_grp : pix_grp;
        gath     = aw_e | ({24'd0, s_payload.data_byte} << {big_e, 3'b000});
        grp_done = ({1'b0, big_e} + 3'd1) >= grp;

        entry     = gath;
        ei_inc    = ei_e + 9'd1;
        pl_after  = pl_e;
        bad_index = ({1'b0, gath} >= {24'd0, map_length_reg}) || ({1'b0, gath} >= DEPTH_W);
        wr_en     = 1'b0;
        rd_en     = 1'b0;
        res_valid = 1'b0;

        pend.lookup      = 1'b0;
        pend.short_entry = (map_fmt_reg == FMT_16) || (map_fmt_reg == FMT_24);
        pend.value       = gath;
        pend.rep         = 8'd1;
        pend.last        = 1'b0;
        pend.err         = 1'b0;

        case (ph_e)
            PH_SKIP: begin
                if (skip_e != 8'd0) begin
                    skip_next = skip_e - 8'd1;
                    if (skip_e == 8'd1) begin
                        if (cmap_entries) begin
                            phase_next = PH_MAP;
                            ei_next    = 9'd0;
                        end else begin
                            phase_next = (pl_e != 32'd0) ? PH_PIX : PH_DONE;
                        end
                    end
                end
            end
            PH_MAP: begin
                if (grp_done) begin
                    big_next = 2'd0;
                    aw_next  = 32'd0;
                    if (map_fmt_reg == FMT_16) begin
                        entry = {7'd0, gath[15], 3'd0, gath[14:10],
                                 3'd0, gath[9:5], 3'd0, gath[4:0]};
                    end
                    wr_en   = {24'd0, ei_e} < DEPTH_W;
                    ei_next = ei_inc;
                    if (ei_inc >= map_length_reg) begin
                        phase_next = (pl_e != 32'd0) ? PH_PIX : PH_DONE;
                    end
                end else begin
                    big_next = big_e + 2'd1;
                    aw_next  = gath;
                end
            end
            PH_PIX: begin
                if (data_mode_reg == MODE_RLE && pkl_e == 8'd0) begin
                    // Packet header: raw when the top bit is clear.
                    raw_next = !s_payload.data_byte[7];
                    pkl_next = {1'b0, s_payload.data_byte[6:0]} + 8'd1;
                end else if (grp_done) begin
                    big_next  = 2'd0;
                    aw_next   = 32'd0;
                    res_valid = 1'b1;
                    if (data_mode_reg == MODE_CMAP) begin
                        pend.err    = bad_index;
                        pend.lookup = !bad_index;
                        rd_en       = !bad_index;
                    end else begin
                        if (pix_grp != 3'd4) begin
                            pend.value = {ALPHA_OPAQUE, gath[23:0]};
                        end
                        if (data_mode_reg == MODE_RLE) begin
                            if (raw_e) begin
                                pkl_next = pkl_e - 8'd1;
                            end else begin
                                pend.rep = ({24'd0, pkl_e} < pl_e) ? pkl_e : pl_e[7:0];
                                pkl_next = 8'd0;
                            end
                        end
                    end
                    pl_after  = pl_e - {24'd0, pend.rep};
                    pl_next   = pl_after;
                    pend.last = (pl_after == 32'd0);
                    if (pl_after == 32'd0) begin
                        phase_next = PH_DONE;
                    end
                end else begin
                    big_next = big_e + 2'd1;
                    aw_next  = gath;
                end
            end
            default: begin
            end
        endcase
    end

    // Configuration writes; the pixel count is kept ready as a product.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            data_mode_reg   <= MODE_TRUE;
            pixel_bytes_reg <= 3'd4;
            map_fmt_reg     <= FMT_32;
            map_length_reg  <= 9'd0;
            width_reg       <= 16'd0;
            height_reg      <= 16'd0;
            id_length_reg   <= 8'd0;
            area_reg        <= 32'd0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_DATA_MODE:   data_mode_reg   <= cfg_wdata[1:0];
                REG_PIXEL_BYTES: pixel_bytes_reg <= cfg_wdata[2:0];
                REG_MAP_FORMAT:  map_fmt_reg     <= cfg_wdata[1:0];
                REG_MAP_LENGTH:  map_length_reg  <= cfg_wdata[8:0];
                REG_WIDTH: begin
                    width_reg <= cfg_wdata;
                    area_reg  <= {16'd0, cfg_wdata} * {16'd0, height_reg};
                end
                REG_HEIGHT: begin
                    height_reg <= cfg_wdata;
                    area_reg   <= {16'd0, width_reg} * {16'd0, cfg_wdata};
                end
                REG_ID_LENGTH:   id_length_reg   <= cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    // Decoder state advances on each input transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_SKIP;
            big_reg   <= 2'd0;
            aw_reg    <= 32'd0;
            skip_reg  <= 8'd0;
            ei_reg    <= 9'd0;
            pl_reg    <= 32'd0;
            pkl_reg   <= 8'd0;
            raw_reg   <= 1'b0;
        end else if (accept) begin
            phase_reg <= phase_next;
            big_reg   <= big_next;
            aw_reg    <= aw_next;
            skip_reg  <= skip_next;
            ei_reg    <= ei_next;
            pl_reg    <= pl_next;
            pkl_reg   <= pkl_next;
            raw_reg   <= raw_next;
        end
    end

    // Color table.
    tgapsd_cmap #(
        .DEPTH (MAP_DEPTH),
        .AW    (AW)
    ) u_cmap (
        .aclk    (aclk),
        .wr_en   (accept && wr_en),
        .wr_addr (AW'(ei_e)),
        .wr_data (entry),
        .rd_en   (accept && rd_en),
        .rd_addr (AW'(gath)),
        .rd_data (rd_data)
    );

    // Pending stage: holds a result while its table read completes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else if (accept) begin
            p_valid_reg <= res_valid;
        end else if (m_free) begin
            p_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && res_valid) begin
            p_reg <= pend;
        end
    end

    // Output register: final pixel value formed from the table data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (m_free) begin
            m_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_free && p_valid_reg) begin
            if (p_reg.err) begin
                m_payload_reg.pixel_bgra <= 32'd0;
            end else if (p_reg.lookup) begin
                m_payload_reg.pixel_bgra <= p_reg.short_entry
                                            ? {ALPHA_OPAQUE, rd_data[23:0]} : rd_data;
            end else begin
                m_payload_reg.pixel_bgra <= p_reg.value;
            end
            m_payload_reg.repeat_count  <= p_reg.rep;
            m_payload_reg.last_of_image <= p_reg.last;
            m_payload_reg.index_error   <= p_reg.err;
        end
    end

`ifndef ASSERT_OFF
    // A pending result moves to the output as soon as the output can take it.
    a_pend_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        p_valid_reg && m_free |=> m_valid_reg)
        else $error("pending result not moved to output");

    // Every result covers at least one pixel.
    a_rep_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_payload_reg.repeat_count != 8'd0)
        else $error("result with zero repeat count");

    // A bad index always yields a zero pixel.
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_payload_reg.index_error |-> m_payload_reg.pixel_bgra == 32'd0)
        else $error("index error with nonzero pixel");

    // The pixel phase is only held while pixels remain.
    a_pix_left: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_PIX |-> pl_reg != 32'd0)
        else $error("pixel phase with no pixels left");
`endif

endmodule

>>> sim/tgapsd_checker.sv
// ----------------------------------------------------------------------------
// TGA pixel stream decoder checker
// Watches the configuration port and both channels, decodes every accepted
// byte with its own model of the decoder and compares each result transfer,
// field by field, with the oldest predicted pixel.
// ----------------------------------------------------------------------------
module tgapsd_checker
    import tgapsd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_valid,
    input  logic        s_ready,
    input  tgapsd_in_t  s_payload,
    input  logic        m_valid,
    input  logic        m_ready,
    input  tgapsd_out_t m_payload,
    output int          fail_count,
    output int          pending_count
);

    localparam int TABLE_DEPTH = 256;

    // Register copies.
    logic [1:0]  mode_r;
    logic [2:0]  pbytes_r;
    logic [1:0]  fmt_r;
    logic [8:0]  maplen_r;
    logic [15:0] width_r;
    logic [15:0] height_r;
    logic [7:0]  idlen_r;

    // Decoder state.
    tgapsd_phase_t phase_q;
    logic [1:0]    grp_pos;
    logic [31:0]   word;
    logic [7:0]    skip_cnt;
    logic [8:0]    entry_cnt;
    logic [31:0]   palette [0:TABLE_DEPTH-1];
    logic [31:0]   pix_left;
    logic [7:0]    pkt_left;
    logic          pkt_raw;

    tgapsd_out_t   pixels_due [$];
    int            mismatches = 0;

    // Bytes per index or per true color pixel.
    function automatic int pixel_group();
        if (mode_r == MODE_CMAP) begin
            return (pbytes_r >= 3'd1 && pbytes_r <= 3'd4) ? int'(pbytes_r) : 4;
        end
        return (pbytes_r == 3'd4) ? 4 : 3;
    endfunction

    // Bytes per color map entry.
    function automatic int entry_group();
        if (fmt_r == FMT_16) begin
            return 2;
        end
        if (fmt_r == FMT_24) begin
            return 3;
        end
        return 4;
    endfunction

    // Adds one byte to the little-endian word; returns 1 once the group is full.
    function automatic bit collect(input logic [7:0] b, input int size);
        word = word | ({24'd0, b} << (8 * grp_pos));
        if (int'(grp_pos) + 1 >= size) begin
            grp_pos = 2'd0;
            return 1'b1;
        end
        grp_pos = grp_pos + 2'd1;
        return 1'b0;
    endfunction

    function automatic void enter_pixels();
        phase_q = (pix_left != 32'd0) ? PH_PIX : PH_DONE;
    endfunction

    function automatic void leave_skip();
        if (mode_r == MODE_CMAP && maplen_r != 9'd0) begin
            phase_q   = PH_MAP;
            entry_cnt = 9'd0;
        end else begin
            enter_pixels();
        end
    endfunction

    // Books one predicted result and updates the pixel count.
    function automatic void emit_pixel(input logic [31:0] value, input logic [31:0] rep,
                                       input logic err);
        tgapsd_out_t r;
        pix_left        = pix_left - rep;
        r.pixel_bgra    = value;
        r.repeat_count  = rep[7:0];
        r.last_of_image = (pix_left == 32'd0);
        r.index_error   = err;
        if (pix_left == 32'd0) begin
            phase_q = PH_DONE;
        end
        pixels_due.push_back(r);
    endfunction

    // Decodes one accepted body byte.
    function automatic void decode_byte(input tgapsd_in_t item);
        logic [7:0]  b;
        logic [31:0] w;
        logic [31:0] rep;
        b = item.data_byte;

        if (item.start_of_image) begin
            pix_left  = {16'd0, width_r} * {16'd0, height_r};
            skip_cnt  = idlen_r;
            entry_cnt = 9'd0;
            grp_pos   = 2'd0;
            word      = 32'd0;
            pkt_left  = 8'd0;
            pkt_raw   = 1'b0;
            if (skip_cnt != 8'd0) begin
                phase_q = PH_SKIP;
            end else begin
                leave_skip();
            end
        end

        case (phase_q)
            PH_SKIP: begin
                if (skip_cnt != 8'd0) begin
                    skip_cnt = skip_cnt - 8'd1;
                    if (skip_cnt == 8'd0) begin
                        leave_skip();
                    end
                end
            end
            PH_MAP: begin
                if (collect(b, entry_group())) begin
                    w    = word;
                    word = 32'd0;
                    // 5-5-5-1 entries keep each channel unscaled in its byte lane.
                    if (fmt_r == FMT_16) begin
                        w = {7'd0, w[15], 3'd0, w[14:10], 3'd0, w[9:5], 3'd0, w[4:0]};
                    end
                    if (entry_cnt < TABLE_DEPTH) begin
                        palette[entry_cnt[7:0]] = w;
                    end
                    entry_cnt = entry_cnt + 9'd1;
                    if (entry_cnt >= maplen_r) begin
                        enter_pixels();
                    end
                end
            end
            PH_PIX: begin
                if (mode_r == MODE_RLE && pkt_left == 8'd0) begin
                    // Packet header: top bit clear means a raw packet.
                    pkt_raw  = ~b[7];
                    pkt_left = {1'b0, b[6:0]} + 8'd1;
                end else if (collect(b, pixel_group())) begin
                    w    = word;
                    word = 32'd0;
                    if (mode_r == MODE_CMAP) begin
                        if (w >= maplen_r || w >= TABLE_DEPTH) begin
                            emit_pixel(32'd0, 32'd1, 1'b1);
                        end else begin
                            w = palette[w[7:0]];
                            if (fmt_r == FMT_16 || fmt_r == FMT_24) begin
                                w = {ALPHA_OPAQUE, w[23:0]};
                            end
                            emit_pixel(w, 32'd1, 1'b0);
                        end
                    end else begin
                        if (pixel_group() != 4) begin
                            w = {ALPHA_OPAQUE, w[23:0]};
                        end
                        if (mode_r != MODE_RLE) begin
                            emit_pixel(w, 32'd1, 1'b0);
                        end else if (pkt_raw) begin
                            pkt_left = pkt_left - 8'd1;
                            emit_pixel(w, 32'd1, 1'b0);
                        end else begin
                            // A run is cut to the pixels left in the image.
                            rep      = ({24'd0, pkt_left} < pix_left) ? {24'd0, pkt_left}
                                                                      : pix_left;
                            pkt_left = 8'd0;
                            emit_pixel(w, rep, 1'b0);
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void write_register(input logic [2:0] idx, input logic [15:0] v);
        case (idx)
            REG_DATA_MODE:   mode_r   = v[1:0];
            REG_PIXEL_BYTES: pbytes_r = v[2:0];
            REG_MAP_FORMAT:  fmt_r    = v[1:0];
            REG_MAP_LENGTH:  maplen_r = v[8:0];
            REG_WIDTH:       width_r  = v;
            REG_HEIGHT:      height_r = v;
            REG_ID_LENGTH:   idlen_r  = v[7:0];
            default: begin
            end
        endcase
    endfunction

    // Per edge: compare the result transfer, then decode the input transfer,
    // then apply a register write.
    always @(posedge aclk) begin
        tgapsd_out_t exp_px;
        if (!aresetn) begin
            mode_r    = MODE_TRUE;
            pbytes_r  = 3'd4;
            fmt_r     = FMT_32;
            maplen_r  = 9'd0;
            width_r   = 16'd0;
            height_r  = 16'd0;
            idlen_r   = 8'd0;
            phase_q   = PH_SKIP;
            grp_pos   = 2'd0;
            word      = 32'd0;
            skip_cnt  = 8'd0;
            entry_cnt = 9'd0;
            pix_left  = 32'd0;
            pkt_left  = 8'd0;
            pkt_raw   = 1'b0;
            pixels_due.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (pixels_due.size() == 0) begin
                    if (mismatches < 40) begin
                        $display("%0t UNEXPECTED expected none, got %h/%0d/%b/%b",
                                 $time, m_payload.pixel_bgra, m_payload.repeat_count,
                                 m_payload.last_of_image, m_payload.index_error);
                    end
                    mismatches++;
                end else begin
                    exp_px = pixels_due.pop_front();
                    if (m_payload.pixel_bgra    !== exp_px.pixel_bgra   ||
                        m_payload.repeat_count  !== exp_px.repeat_count ||
                        m_payload.last_of_image !== exp_px.last_of_image ||
                        m_payload.index_error   !== exp_px.index_error) begin
                        if (mismatches < 40) begin
                            $display("%0t MISMATCH expected %h/%0d/%b/%b got %h/%0d/%b/%b",
                                     $time, exp_px.pixel_bgra, exp_px.repeat_count,
                                     exp_px.last_of_image, exp_px.index_error,
                                     m_payload.pixel_bgra, m_payload.repeat_count,
                                     m_payload.last_of_image, m_payload.index_error);
                        end
                        mismatches++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                decode_byte(s_payload);
            end
            if (cfg_we) begin
                write_register(cfg_index, cfg_wdata);
            end
        end
        pending_count <= pixels_due.size();
        fail_count    <= mismatches;
    end

endmodule

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// TGA pixel stream decoder testbench
// Programs the header registers, streams image bodies (directed cases first,
// then random images, noise and cut-off streams) with random gaps and result
// stalls, and reports the verdict of the checker.
// ----------------------------------------------------------------------------
module tb_top;
    import tgapsd_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int ITEM_TARGET  = 1150;
    localparam int SETTLE_CYCLES = 4;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_index = 3'd0;
    logic [15:0] cfg_wdata = 16'd0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    tgapsd_in_t  s_payload = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    tgapsd_out_t m_payload;

    int fail_count;
    int pending_count;
    int cycle_count = 0;
    int items_sent  = 0;
    bit no_gaps     = 1'b0;
    bit sof_next    = 1'b0;
    int cut_left    = 32'h7FFF_FFFF;

    // Current register settings, used to shape the byte streams.
    logic [1:0]  cur_mode;
    logic [2:0]  cur_pb;
    logic [1:0]  cur_fmt;
    logic [8:0]  cur_maplen;
    logic [15:0] cur_w;
    logic [15:0] cur_h;
    logic [7:0]  cur_id;

    tga_pixel_stream_decoder_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    tgapsd_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_payload     (s_payload),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_payload     (m_payload),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // Clock, period 8.
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Run watchdog.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Result side: a random stall before each result transfer.
    initial begin
        int stall;
        @(posedge aclk);
        forever begin
            stall = no_gaps ? 0 : $urandom_range(0, 14);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // One byte transfer after a random gap; returns at the accepting edge.
    task automatic send_byte(input logic [7:0] d, input bit sof);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= tgapsd_in_t'{data_byte: d, start_of_image: sof};
        do @(posedge aclk); while (!s_ready);
    endtask

    // Next byte of the current stream; the first one carries start_of_image.
    // The stream stops once the item budget or the cut-off length is used up.
    task automatic put(input logic [7:0] d);
        if (cut_left == 0 || items_sent >= ITEM_TARGET) begin
            return;
        end
        cut_left--;
        send_byte(d, sof_next);
        sof_next = 1'b0;
        items_sent++;
    endtask

    // Hold the sender until every predicted pixel has arrived.
    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_count != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] v);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic configure(input logic [1:0] mode, input logic [2:0] pb,
                             input logic [1:0] fmt, input logic [8:0] maplen,
                             input logic [15:0] w, input logic [15:0] h,
                             input logic [7:0] id);
        settle();
        write_reg(REG_DATA_MODE,   {14'd0, mode});
        write_reg(REG_PIXEL_BYTES, {13'd0, pb});
        write_reg(REG_MAP_FORMAT,  {14'd0, fmt});
        write_reg(REG_MAP_LENGTH,  {7'd0, maplen});
        write_reg(REG_WIDTH,       w);
        write_reg(REG_HEIGHT,      h);
        write_reg(REG_ID_LENGTH,   {8'd0, id});
        cur_mode   = mode;
        cur_pb     = pb;
        cur_fmt    = fmt;
        cur_maplen = maplen;
        cur_w      = w;
        cur_h      = h;
        cur_id     = id;
    endtask

    // A well-formed body for the current settings, optionally cut off early.
    task automatic send_image(input bit truncate);
        int          g;
        int          eb;
        int          cnt;
        longint      n;
        longint      remaining;
        logic [31:0] idx;
        logic [7:0]  hdr;

        if (cur_mode == MODE_CMAP) begin
            g = (cur_pb >= 3'd1 && cur_pb <= 3'd4) ? int'(cur_pb) : 4;
        end else begin
            g = (cur_pb == 3'd4) ? 4 : 3;
        end
        eb = (cur_fmt == FMT_16) ? 2 : ((cur_fmt == FMT_24) ? 3 : 4);
        n  = longint'(cur_w) * longint'(cur_h);

        sof_next = 1'b1;
        cut_left = truncate ? $urandom_range(1, 20) : 32'h7FFF_FFFF;

        repeat (cur_id) put(8'($urandom));
        if (cur_mode == MODE_CMAP && cur_maplen != 9'd0) begin
            repeat (int'(cur_maplen) * eb) put(8'($urandom));
        end

        if (cur_mode == MODE_CMAP) begin
            // Mostly valid indices, some out of range.
            repeat (n) begin
                if ($urandom_range(0, 5) != 0 && cur_maplen != 9'd0) begin
                    idx = $urandom_range(0, int'(cur_maplen) - 1);
                end else begin
                    idx = $urandom;
                end
                for (int k = 0; k < g; k++) begin
                    put(8'(idx >> (8 * k)));
                end
            end
        end else if (cur_mode == MODE_RLE) begin
            // Packets with mostly short counts; raw packets stop at image end.
            remaining = n;
            while (remaining > 0) begin
                hdr = 8'($urandom);
                if ($urandom_range(0, 3) != 0) begin
                    hdr[6:0] = 7'($urandom_range(0, 4));
                end
                cnt = int'(hdr[6:0]) + 1;
                if (longint'(cnt) > remaining) begin
                    cnt = int'(remaining);
                end
                put(hdr);
                if (hdr[7]) begin
                    repeat (g) put(8'($urandom));
                end else begin
                    repeat (cnt * g) put(8'($urandom));
                end
                remaining = remaining - cnt;
            end
        end else begin
            repeat (n * g) put(8'($urandom));
        end

        // Trailing bytes after the image are ignored by the block.
        if (!truncate) begin
            repeat (sof_next ? $urandom_range(1, 2) : $urandom_range(0, 2)) begin
                put(8'($urandom));
            end
        end
    endtask

    // Random bytes that start a fresh image and may restart it again.
    task automatic send_noise();
        sof_next = 1'b1;
        cut_left = 32'h7FFF_FFFF;
        repeat ($urandom_range(3, 12)) begin
            put(8'($urandom));
            if ($urandom_range(0, 7) == 0) begin
                sof_next = 1'b1;
            end
        end
    endtask

    // Stimulus and verdict.
    initial begin
        int          it;
        logic [1:0]  mode;
        logic [2:0]  pb;
        logic [8:0]  maplen;
        logic [15:0] w;
        logic [15:0] h;
        logic [7:0]  id;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Bytes before any start of image are ignored.
        put(8'hA5);
        put(8'h5A);

        // Raw 24-bit true color: alpha is filled in.
        configure(MODE_TRUE, 3'd3, FMT_32, 9'd0, 16'd2, 16'd1, 8'd0);
        sof_next = 1'b1;
        put(8'hFF); put(8'hFF); put(8'hFF);
        put(8'h00); put(8'h00); put(8'h00);

        // Color map with 16-bit entries, one ID byte and one index past the map.
        configure(MODE_CMAP, 3'd1, FMT_16, 9'd2, 16'd3, 16'd1, 8'd1);
        sof_next = 1'b1;
        put(8'h3C);
        put(8'hFF); put(8'hFF);
        put(8'h00); put(8'h00);
        put(8'h01); put(8'h00); put(8'h02);

        // Longest run, cut to the image size, then an ignored byte.
        configure(MODE_RLE, 3'd4, FMT_32, 9'd0, 16'd3, 16'd1, 8'd0);
        sof_next = 1'b1;
        put(8'hFF);
        put(8'hFF); put(8'hFF); put(8'hFF); put(8'hFF);
        put(8'h00);

        // Longest raw packet, stopped at the last pixel.
        configure(MODE_RLE, 3'd3, FMT_24, 9'd0, 16'd2, 16'd1, 8'd0);
        sof_next = 1'b1;
        put(8'h7F);
        put(8'h12); put(8'h34); put(8'h56);
        put(8'hAB); put(8'hCD); put(8'hEF);

        // Random phases, each with its own register settings.
        it = 0;
        while (items_sent < ITEM_TARGET) begin
            mode = 2'($urandom_range(0, 3));
            if (mode == MODE_CMAP) begin
                if ($urandom_range(0, 5) == 0) begin
                    pb = 3'($urandom_range(4, 7));
                    if (pb == 3'd4) begin
                        pb = 3'd0;
                    end
                end else begin
                    pb = 3'($urandom_range(1, 4));
                end
            end else if ($urandom_range(0, 5) == 0) begin
                pb = 3'($urandom_range(0, 7));
            end else begin
                pb = $urandom_range(0, 1) ? 3'd3 : 3'd4;
            end
            maplen = ($urandom_range(0, 9) == 0) ? 9'd0 : 9'($urandom_range(1, 8));
            w      = 16'($urandom_range(0, 6));
            h      = 16'($urandom_range(0, 5));
            if ($urandom_range(0, 11) == 0) begin
                if ($urandom_range(0, 1)) begin
                    w = 16'hFFFF;
                    h = 16'd0;
                end else begin
                    w = 16'd0;
                    h = 16'hFFFF;
                end
            end
            id = ($urandom_range(0, 9) < 7) ? 8'd0 : 8'($urandom_range(1, 4));

            // A few phases reach the largest sizes.
            if (it == 2) begin
                id = 8'hFF;
            end
            if (it == 4) begin
                mode   = MODE_CMAP;
                pb     = 3'd1;
                maplen = 9'd256;
                w      = 16'd6;
                h      = 16'd2;
                configure(mode, pb, FMT_16, maplen, w, h, id);
            end else if (it == 6) begin
                mode = MODE_RLE;
                pb   = 3'd4;
                w    = 16'd130;
                h    = 16'd1;
                configure(mode, pb, FMT_32, maplen, w, h, id);
            end else begin
                configure(mode, pb, 2'($urandom_range(0, 3)), maplen, w, h, id);
            end

            no_gaps = ($urandom_range(0, 4) == 0);
            repeat ($urandom_range(1, 3)) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_noise();
                end else begin
                    send_image($urandom_range(0, 7) == 0);
                end
            end
            it++;
        end

        settle();
        if (fail_count == 0 && pending_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
